FILE: hw/rtl/assert_macros.svh
// assertion macros used by text_console_writer.sv
// clock i_clk and active-low reset i_rst_n are taken from the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define TCW_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define TCW_ASSERT(name, prop)
`define TCW_ASSERT_NEVER(name, expr)
`endif
`endif

FILE: hw/rtl/tcw_pkg.sv
// constants and codes for the text console writer
// no dependencies
`default_nettype none
package tcw_pkg;
    localparam int CMD_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = 13;
    localparam int DATA_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ATTR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK = 1'b1;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'd7;
    localparam logic [DATA_W-1:0] RESET_BLANK = 16'h0720;
endpackage
`default_nettype wire

FILE: hw/rtl/tcw_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/text_console_writer.sv
// text console writer: cursor and scroll sequencer over a video cell memory
// uses tcw_pkg, tcw_ram and assert_macros.svh
//
// usage
//   input channel s_*: one command item per handshake. tuser carries the command
//   (write character, clear memory, read cell), tlast marks the last character of a
//   write and publishes the cursor. tdata carries the character and the cell index.
//   output channel m_*: exactly one result item per command with the published
//   cursor, the display start and the cell read (zero for other commands).
//   config port: i_cfg_we writes register i_cfg_idx (0 attribute, 1 blank cell).
// execution
//   plain characters and cursor moves are accepted and then executed in ST_EXEC, with at
//   most one memory write; reads go on to ST_READ for the registered ram read.
//   a line move on the last row scrolls: when the window and its new row would run past
//   the memory end, the window is first copied back to the memory start, then the new row is blanked,
//   at one cell per cycle through the ram ports. a clear writes all MEM_CELLS cells.
// reset
//   after reset a clearing pass writes the blank cell to all MEM_CELLS cells; s_tready
//   stays low during that pass. config writes are taken meanwhile.
// stall
//   a finished result waits in the output register; the next item is still accepted,
//   and its own result waits in the sequencer until the output register frees.
`default_nettype none
`include "assert_macros.svh"
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int MEM_CELLS = 8192
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // char_code [7:0], read_cell [20:8], zeros above
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // cmd [1:0]
    input  wire logic [CMD_W-1:0]       s_tuser,
    input  wire logic                   s_tlast,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // cursor_out [12:0], screen_out [25:13], cell_data [41:26], zeros above
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [DATA_W-1:0]      i_cfg_data
);
    localparam int AW    = $clog2(MEM_CELLS);
    localparam int COL_W = $clog2(COLUMNS + 1);
    localparam int ROW_W = $clog2(ROWS);
    localparam int SPAN  = COLUMNS * ROWS;
    localparam int CNT_W = $clog2(SPAN);
    localparam int PAD_W = OUT_TDATA_W - 2 * CELL_W - DATA_W;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_EXEC, ST_READ, ST_SCROLL, ST_COPY, ST_COPY_END,
        ST_ROWCLR, ST_SCR_END, ST_POST, ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        POST_NONE, POST_COL0, POST_PRINT
    } t_post;

    function automatic logic [AW-1:0] f_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(MEM_CELLS)) begin
            s = s - (AW+1)'(MEM_CELLS);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + (AW+1)'(MEM_CELLS) - {1'b0, b};
        end
        return s[AW-1:0];
    endfunction

    t_state             r_state, n_state;
    t_post              r_post, n_post;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [CHAR_W-1:0]  r_ch, n_ch;
    logic               r_last, n_last;
    logic [CELL_W-1:0]  r_raddr, n_raddr;
    logic [ATTR_W-1:0]  r_attr, n_attr;
    logic [DATA_W-1:0]  r_blank, n_blank;
    logic [AW-1:0]      r_ss, n_ss;
    logic [AW-1:0]      r_cursor, n_cursor;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [AW-1:0]      r_pub, n_pub;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]      r_src, n_src;
    logic [AW-1:0]      r_dst, n_dst;
    logic               r_cp_wr, n_cp_wr;
    logic               r_init, n_init;
    logic [DATA_W-1:0]  r_data, n_data;
    logic               r_out_valid, n_out_valid;
    logic [CELL_W-1:0]  r_out_cursor, n_out_cursor;
    logic [CELL_W-1:0]  r_out_screen, n_out_screen;
    logic [DATA_W-1:0]  r_out_data, n_out_data;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;
    logic               do_fin;
    logic               out_free;
    logic               row_ok;
    logic [AW-1:0]      pub_val;

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{PAD_W{1'b0}}, r_out_data, r_out_screen, r_out_cursor};
    assign out_free = !r_out_valid || m_tready;
    assign row_ok   = (r_row < ROW_W'(ROWS - 1));

    always_comb begin
        n_state      = r_state;
        n_post       = r_post;
        n_cmd        = r_cmd;
        n_ch         = r_ch;
        n_last       = r_last;
        n_raddr      = r_raddr;
        n_attr       = r_attr;
        n_blank      = r_blank;
        n_ss         = r_ss;
        n_cursor     = r_cursor;
        n_col        = r_col;
        n_row        = r_row;
        n_pub        = r_pub;
        n_cnt        = r_cnt;
        n_src        = r_src;
        n_dst        = r_dst;
        n_cp_wr      = r_cp_wr;
        n_init       = r_init;
        n_data       = r_data;
        n_out_valid  = r_out_valid;
        n_out_cursor = r_out_cursor;
        n_out_screen = r_out_screen;
        n_out_data   = r_out_data;
        ram_we       = 1'b0;
        ram_waddr    = r_dst;
        ram_wdata    = r_blank;
        ram_raddr    = r_src;
        do_fin       = 1'b0;
        pub_val      = r_pub;

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ATTR:  n_attr = i_cfg_data[ATTR_W-1:0];
                REG_BLANK: n_blank = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst;
                ram_wdata = r_init ? RESET_BLANK : r_blank;
                n_dst     = r_dst + AW'(1);
                if (r_dst == AW'(MEM_CELLS - 1)) begin
                    n_dst = '0;
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        do_fin = 1'b1;
                    end
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_cmd   = s_tuser;
                    n_ch    = s_tdata[CHAR_W-1:0];
                    n_raddr = s_tdata[CHAR_W +: CELL_W];
                    n_last  = s_tlast;
                    n_data  = '0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_cmd)
                    CMD_WRITE: begin
                        case (r_ch)
                            CH_BS: begin
                                if (r_col != '0) begin
                                    n_col     = r_col - COL_W'(1);
                                    n_cursor  = f_sub(r_cursor, AW'(1));
                                    ram_we    = 1'b1;
                                    ram_waddr = n_cursor;
                                    ram_wdata = r_blank;
                                end
                                do_fin = 1'b1;
                            end
                            CH_LF: begin
                                if (row_ok) begin
                                    n_row    = r_row + ROW_W'(1);
                                    n_cursor = f_add(r_cursor,
                                                     AW'(COL_W'(COLUMNS) - r_col));
                                    n_col    = '0;
                                    do_fin   = 1'b1;
                                end else begin
                                    n_post  = POST_COL0;
                                    n_state = ST_SCROLL;
                                end
                            end
                            CH_FF: begin
                                if (row_ok) begin
                                    n_row    = r_row + ROW_W'(1);
                                    n_cursor = f_add(r_cursor, AW'(COLUMNS));
                                    do_fin   = 1'b1;
                                end else begin
                                    n_post  = POST_NONE;
                                    n_state = ST_SCROLL;
                                end
                            end
                            CH_CR: begin
                                n_cursor = f_sub(r_cursor, AW'(r_col));
                                n_col    = '0;
                                do_fin   = 1'b1;
                            end
                            CH_DEL: begin
                                ram_we    = 1'b1;
                                ram_waddr = r_cursor;
                                ram_wdata = r_blank;
                                do_fin    = 1'b1;
                            end
                            default: begin
                                if (r_ch < CH_SPACE) begin
                                    do_fin = 1'b1;
                                end else if (r_col >= COL_W'(COLUMNS) && !row_ok) begin
                                    // wrap on the last row: scroll first, print after
                                    n_col    = r_col - COL_W'(COLUMNS);
                                    n_cursor = f_sub(r_cursor, AW'(COLUMNS));
                                    n_post   = POST_PRINT;
                                    n_state  = ST_SCROLL;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_cursor;
                                    ram_wdata = {r_attr, r_ch};
                                    n_cursor  = f_add(r_cursor, AW'(1));
                                    if (r_col >= COL_W'(COLUMNS)) begin
                                        n_row = r_row + ROW_W'(1);
                                        n_col = r_col - COL_W'(COLUMNS) + COL_W'(1);
                                    end else begin
                                        n_col = r_col + COL_W'(1);
                                    end
                                    do_fin = 1'b1;
                                end
                            end
                        endcase
                    end
                    CMD_CLEAR: begin
                        n_ss     = '0;
                        n_cursor = '0;
                        n_col    = '0;
                        n_row    = '0;
                        n_pub    = '0;
                        n_dst    = '0;
                        n_state  = ST_CLEAR;
                    end
                    CMD_READ: begin
                        ram_raddr = r_raddr[AW-1:0];
                        n_state   = ST_READ;
                    end
                    default: begin
                        do_fin = 1'b1;
                    end
                endcase
            end
            ST_READ: begin
                if ({1'b0, r_raddr} < (CELL_W+1)'(MEM_CELLS)) begin
                    n_data = ram_rdata;
                end else begin
                    n_data = '0;
                end
                do_fin = 1'b1;
            end
            ST_SCROLL: begin
                n_cnt = '0;
                if ({1'b0, r_ss} + (AW+1)'(SPAN + COLUMNS) >= (AW+1)'(MEM_CELLS)) begin
                    n_src   = r_ss;
                    n_cp_wr = 1'b0;
                    n_state = ST_COPY;
                end else begin
                    n_dst   = r_ss + AW'(SPAN);
                    n_state = ST_ROWCLR;
                end
            end
            ST_COPY: begin
                ram_raddr = r_src;
                n_src     = r_src + AW'(1);
                n_cnt     = r_cnt + CNT_W'(1);
                n_dst     = AW'(r_cnt);
                n_cp_wr   = 1'b1;
                if (r_cp_wr) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dst;
                    ram_wdata = ram_rdata;
                end
                if (r_cnt == CNT_W'(SPAN - 1)) begin
                    n_state = ST_COPY_END;
                end
            end
            ST_COPY_END: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst;
                ram_wdata = ram_rdata;
                n_cp_wr   = 1'b0;
                n_cursor  = f_sub(r_cursor, r_ss);
                n_ss      = '0;
                n_dst     = AW'(SPAN);
                n_cnt     = '0;
                n_state   = ST_ROWCLR;
            end
            ST_ROWCLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst;
                ram_wdata = r_blank;
                n_dst     = r_dst + AW'(1);
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(COLUMNS - 1)) begin
                    n_state = ST_SCR_END;
                end
            end
            ST_SCR_END: begin
                n_ss     = f_add(r_ss, AW'(COLUMNS));
                n_cursor = f_add(r_cursor, AW'(COLUMNS));
                n_state  = ST_POST;
            end
            ST_POST: begin
                case (r_post)
                    POST_COL0: begin
                        n_cursor = f_sub(r_cursor, AW'(r_col));
                        n_col    = '0;
                    end
                    POST_PRINT: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_cursor;
                        ram_wdata = {r_attr, r_ch};
                        n_cursor  = f_add(r_cursor, AW'(1));
                        n_col     = r_col + COL_W'(1);
                    end
                    default: ;
                endcase
                do_fin = 1'b1;
            end
            ST_FIN: begin
                do_fin = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // publish the result once the output register is free
        if (do_fin) begin
            if (out_free) begin
                if (r_cmd == CMD_WRITE && r_last) begin
                    pub_val = n_cursor;
                end else begin
                    pub_val = n_pub;
                end
                n_pub        = pub_val;
                n_out_valid  = 1'b1;
                n_out_cursor = CELL_W'(pub_val);
                n_out_screen = CELL_W'(n_ss);
                n_out_data   = n_data;
                n_state      = ST_IDLE;
            end else begin
                n_state = ST_FIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_post      <= POST_NONE;
            r_attr      <= RESET_ATTR;
            r_blank     <= RESET_BLANK;
            r_ss        <= '0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_pub       <= '0;
            r_cnt       <= '0;
            r_dst       <= '0;
            r_cp_wr     <= 1'b0;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_post      <= n_post;
            r_attr      <= n_attr;
            r_blank     <= n_blank;
            r_ss        <= n_ss;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pub       <= n_pub;
            r_cnt       <= n_cnt;
            r_dst       <= n_dst;
            r_cp_wr     <= n_cp_wr;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_ch         <= n_ch;
        r_last       <= n_last;
        r_raddr      <= n_raddr;
        r_src        <= n_src;
        r_data       <= n_data;
        r_out_cursor <= n_out_cursor;
        r_out_screen <= n_out_screen;
        r_out_data   <= n_out_data;
    end

    `TCW_ASSERT(a_col_range, r_col <= COL_W'(COLUMNS))
    `TCW_ASSERT(a_row_range, r_row <= ROW_W'(ROWS - 1))
    `TCW_ASSERT(a_cursor_range, (r_cursor <= AW'(MEM_CELLS - 1)) && (r_ss <= AW'(MEM_CELLS - 1)))
    `TCW_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready)
    `TCW_ASSERT_NEVER(a_fin_free, (r_state == ST_FIN) && $past(r_state) == ST_FIN && !$past(r_out_valid))
endmodule
`default_nettype wire
